// ===== sv/fbfa_pkg.sv =====
// shared types and constants for the fixed block free-list allocator
package fbfa_pkg;

  // operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FREE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // register select, taken from paddr[2]
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  localparam logic [8:0]  BLOCK_COUNT_RESET = 9'd256;
  localparam logic [15:0] BLOCK_BYTES_RESET = 16'd16;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic link;
    logic sweep;
    logic sweep_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic link_needed;
    logic sweep_last;
  } sts_t;

endpackage

// ===== sv/fbfa_if.sv =====
// request and response channel interfaces
interface fbfa_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink (input valid, input operation, input block_index, output ready);
endinterface

interface fbfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  granted_index;
  logic [23:0] byte_offset;

  modport source (output valid, output status, output granted_index, output byte_offset,
                  input ready);
  modport sink (input valid, input status, input granted_index, input byte_offset,
                output ready);
endinterface

// ===== sv/fbfa_cfg.sv =====
// apb-style configuration registers
module fbfa_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  block_count,
  output logic [15:0] block_bytes,
  output logic        rebuild
);
  import fbfa_pkg::*;

  logic wr;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  // every register write rebuilds the list
  assign rebuild = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (wr) begin
      if (paddr[2] == REG_BLOCK_COUNT) begin
        block_count <= pwdata[8:0];
      end else begin
        block_bytes <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BLOCK_COUNT) begin
      prdata = {23'd0, block_count};
    end else begin
      prdata = {16'd0, block_bytes};
    end
  end

endmodule

// ===== sv/fbfa_ctrl.sv =====
// sequencing state machine
module fbfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               rebuild,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbfa_pkg::sts_t     sts,
  output fbfa_pkg::cmd_t     cmd
);
  import fbfa_pkg::*;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_LINK  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.sweep_clear = rebuild;
    state_next      = state;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = !rebuild;
        if (!rebuild && sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = sts.link_needed ? S_LINK : S_IDLE;
        end
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
    if (rebuild) begin
      state_next = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/fbfa_datapath.sv =====
// link and free-mark memories, head register, result register
module fbfa_datapath #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  fbfa_pkg::cmd_t  cmd,
  output fbfa_pkg::sts_t  sts,
  input  logic [8:0]      block_count,
  input  logic [15:0]     block_bytes,
  input  logic            operation,
  input  logic [7:0]      block_index,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [7:0]      granted_index,
  output logic [23:0]     byte_offset
);
  import fbfa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int LINK_W = IDX_W + 1;
  localparam int XW     = (LINK_W > 9) ? LINK_W : 9;
  localparam int PW     = (LINK_W + 16 > 24) ? LINK_W + 16 : 24;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
  logic              free_mem [MAX_BLOCKS];

  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] link_rd;
  logic              free_rd;
  logic              op_q;
  logic [7:0]        idx_q;
  logic [IDX_W-1:0]  sweep_cnt;

  logic [XW-1:0]     count_x;
  logic [LINK_W-1:0] active;
  logic [XW-1:0]     in_idx_x;
  logic [XW-1:0]     idx_q_x;
  logic [IDX_W-1:0]  idx_addr_q;
  logic [IDX_W-1:0]  head_addr;
  logic              head_null;
  logic              range_bad;
  logic              grant_ok;
  logic              rel_ok;
  logic [1:0]        ex_status;
  logic [LINK_W-1:0] sweep_nxt;
  logic [PW-1:0]     prod;

  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              free_we;
  logic [IDX_W-1:0]  free_wa;
  logic              free_wd;

  // effective count, clamped to the pool depth
  assign count_x = XW'(block_count);
  assign active  = (count_x > XW'(MAX_BLOCKS)) ? NULL_LINK : count_x[LINK_W-1:0];

  assign in_idx_x   = XW'(block_index);
  assign idx_q_x    = XW'(idx_q);
  assign idx_addr_q = idx_q_x[IDX_W-1:0];
  assign head_addr  = head[IDX_W-1:0];
  assign head_null  = (head == NULL_LINK);
  assign range_bad  = (idx_q_x >= XW'(active));
  assign grant_ok   = (op_q == OP_ALLOC) && !head_null;
  assign rel_ok     = (op_q == OP_RELEASE) && !range_bad && !free_rd;
  assign sweep_nxt  = LINK_W'(sweep_cnt) + LINK_W'(1);
  assign prod       = PW'(head) * PW'(block_bytes);

  always_comb begin
    if (op_q == OP_ALLOC) begin
      ex_status = head_null ? ST_EMPTY : ST_OK;
    end else if (range_bad) begin
      ex_status = ST_RANGE;
    end else if (free_rd) begin
      ex_status = ST_FREE;
    end else begin
      ex_status = ST_OK;
    end
  end

  assign sts.out_free    = !out_valid || out_ready;
  assign sts.link_needed = rel_ok && !head_null;
  assign sts.sweep_last  = (sweep_cnt == IDX_W'(MAX_BLOCKS - 1));

  // single write port per memory
  always_comb begin
    link_we = 1'b0;
    link_wa = sweep_cnt;
    link_wd = NULL_LINK;
    free_we = 1'b0;
    free_wa = sweep_cnt;
    free_wd = 1'b1;
    priority if (cmd.sweep) begin
      link_we = 1'b1;
      link_wd = (sweep_nxt < active) ? sweep_nxt : NULL_LINK;
      free_we = 1'b1;
    end else if (cmd.exec && rel_ok) begin
      link_we = 1'b1;
      link_wa = idx_addr_q;
      link_wd = head_null ? NULL_LINK : link_rd;
      free_we = 1'b1;
      free_wa = idx_addr_q;
    end else if (cmd.exec && grant_ok) begin
      free_we = 1'b1;
      free_wa = head_addr;
      free_wd = 1'b0;
    end else if (cmd.link) begin
      link_we = 1'b1;
      link_wa = head_addr;
      link_wd = LINK_W'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (cmd.accept) begin
      link_rd <= link_mem[head_addr];
      free_rd <= free_mem[in_idx_x[IDX_W-1:0]];
      op_q    <= operation;
      idx_q   <= block_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_clear) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (cmd.sweep && sts.sweep_last) begin
      head <= (active != '0) ? '0 : NULL_LINK;
    end else if (cmd.exec && grant_ok) begin
      head <= link_rd;
    end else if (cmd.exec && rel_ok && head_null) begin
      head <= LINK_W'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= ex_status;
      granted_index <= grant_ok ? 8'(head) : 8'd0;
      byte_offset   <= grant_ok ? prod[23:0] : 24'd0;
    end
  end

endmodule

// ===== sv/fixed_block_free_list_allocator_top.sv =====
// top level: fixed-size block free-list allocator
// the result register loads in execute, after the request transfer, once the output is free
// a new item is taken only in idle, so not before the last one is done; a release linked behind a
// non-empty head also passes through link to write the head's link entry; a waiting result stalls an item in execute
// reset and every register write rebuild all MAX_BLOCKS entries of the list, one entry per cycle
// no item is taken during the rebuild; register writes are always taken
module fixed_block_free_list_allocator_top #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst,
  fbfa_req_if.sink    req,
  fbfa_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbfa_pkg::*;

  // register values and rebuild strobe
  logic [8:0]  block_count;
  logic [15:0] block_bytes;
  logic        rebuild;

  // controller and datapath handshake
  cmd_t cmd;
  sts_t sts;

  // block_count at 0, block_bytes at 4
  fbfa_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .block_count (block_count),
    .block_bytes (block_bytes),
    .rebuild     (rebuild)
  );

  // sweep, idle, execute, link
  fbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rebuild  (rebuild),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories are read on transfer, written by the sweep and on execute and link, result registered
  fbfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .block_count   (block_count),
    .block_bytes   (block_bytes),
    .operation     (req.operation),
    .block_index   (req.block_index),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .granted_index (rsp.granted_index),
    .byte_offset   (rsp.byte_offset)
  );

endmodule

// ===== sim/testbench.sv =====
// testbench for the fixed block free-list allocator, checked against its own allocation predictor
`timescale 1ns / 1ps

module testbench;
  import fbfa_pkg::*;

  localparam int          POOL_SLOTS    = 256;
  localparam logic [8:0]  LINK_END      = 9'd256;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // predicts every grant and release status, and holds the grants still to come
  class alloc_scoreboard;
    typedef struct {
      logic [1:0]  status;
      logic [7:0]  granted_index;
      logic [23:0] byte_offset;
    } grant_t;

    logic [8:0]  link_next[POOL_SLOTS];
    bit          block_free[POOL_SLOTS];
    logic [8:0]  head;
    logic [8:0]  count_reg;
    logic [15:0] bytes_reg;
    grant_t      expected_grants[$];
    int unsigned errors;

    function int unsigned usable_blocks();
      return (count_reg > POOL_SLOTS) ? POOL_SLOTS : int'(count_reg);
    endfunction

    // chain 0,1,...,n-1 with every block free
    function void rebuild();
      int unsigned n;
      n = usable_blocks();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        link_next[i]  = (i + 1 < n) ? 9'(i + 1) : LINK_END;
        block_free[i] = 1'b1;
      end
      head = (n > 0) ? 9'd0 : LINK_END;
    endfunction

    function void reset_state();
      count_reg = BLOCK_COUNT_RESET;
      bytes_reg = BLOCK_BYTES_RESET;
      errors    = 0;
      rebuild();
    endfunction

    function void write_register(logic sel, logic [31:0] value);
      if (sel == REG_BLOCK_COUNT) begin
        count_reg = value[8:0];
      end else begin
        bytes_reg = value[15:0];
      end
      rebuild();
    endfunction

    function void note_request(logic op, logic [7:0] idx);
      grant_t     g;
      logic [7:0] taken;
      g = '{status: ST_OK, granted_index: 8'd0, byte_offset: 24'd0};
      if (op == OP_ALLOC) begin
        if (head[8]) begin
          g.status = ST_EMPTY;
        end else begin
          taken             = head[7:0];
          g.granted_index   = taken;
          g.byte_offset     = 24'(taken) * 24'(bytes_reg);
          block_free[taken] = 1'b0;
          head              = link_next[taken];
        end
      end else if (idx >= usable_blocks()) begin
        g.status = ST_RANGE;
      end else if (block_free[idx]) begin
        g.status = ST_FREE;
      end else begin
        block_free[idx] = 1'b1;
        if (head[8]) begin
          // empty list: the block becomes the whole list
          link_next[idx] = LINK_END;
          head           = {1'b0, idx};
        end else begin
          // linked directly behind the head
          link_next[idx]       = link_next[head[7:0]];
          link_next[head[7:0]] = {1'b0, idx};
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void pick_held_block(output bit found, output logic [7:0] idx);
      logic [7:0] held[$];
      for (int i = 0; i < int'(usable_blocks()); i++) begin
        if (!block_free[i]) held.push_back(8'(i));
      end
      found = (held.size() != 0);
      idx   = 8'd0;
      if (found) idx = held[$urandom_range(0, held.size() - 1)];
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [1:0] status, logic [7:0] granted_index, logic [23:0] byte_offset);
      grant_t g;
      if (expected_grants.size() == 0) begin
        report($sformatf("result with no request waiting (status %0d index %0d)",
                         status, granted_index));
        return;
      end
      g = expected_grants.pop_front();
      if (status !== g.status)
        report($sformatf("status %0d, expected %0d", status, g.status));
      if (granted_index !== g.granted_index)
        report($sformatf("granted_index %0d, expected %0d", granted_index, g.granted_index));
      if (byte_offset !== g.byte_offset)
        report($sformatf("byte_offset %0d, expected %0d", byte_offset, g.byte_offset));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned     cycle_count = 0;
  int unsigned     burst_left  = 0;
  alloc_scoreboard sb;

  fbfa_req_if req_ch ();
  fbfa_rsp_if rsp_ch ();

  fixed_block_free_list_allocator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // response side: check each transfer, then stall on a pattern that cycle_count[9:8] selects
  // among no stalls, light, heavy and long bursty stalls
  initial begin : response_side
    int unsigned stall_left;
    logic        take;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.status, rsp_ch.granted_index, rsp_ch.byte_offset);
      case (cycle_count[9:8])
        2'd0: take = 1'b1;
        2'd1: take = ($urandom_range(0, 9) < 7);
        2'd2: take = ($urandom_range(0, 4) == 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            take = 1'b0;
          end else begin
            take = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
      rsp_ch.ready <= take;
    end
  end

  // drain: drop valid and wait until every predicted result has come back
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // one request transfer; bursts of random length with random gaps between
  task automatic send_item(logic op, logic [7:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 24) == 0) begin
        // hold off until the block has answered everything
        quiesce();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.block_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, idx);
    burst_left--;
  endtask

  // setup then access phase; the register takes the value at the access edge
  task automatic write_register(logic sel, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers change only with the block idle; each write rebuilds the list
  task automatic configure(logic [31:0] count, logic [31:0] bytes);
    quiesce();
    write_register(REG_BLOCK_COUNT, count);
    write_register(REG_BLOCK_BYTES, bytes);
  endtask

  task automatic directed_items();
    // default pool of 256 blocks, 16 bytes each
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'hFF);
    send_item(OP_ALLOC, 8'h55);
    send_item(OP_RELEASE, 8'd1);    // links behind the head
    send_item(OP_RELEASE, 8'd1);    // already free
    send_item(OP_RELEASE, 8'd200);  // never allocated, still free
    send_item(OP_ALLOC, 8'hAA);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'hFF);
    // two blocks of the largest size: exhaust, then rebuild from an empty list
    configure(32'd2, 32'd65535);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_ALLOC, 8'h00);     // pool empty
    send_item(OP_RELEASE, 8'd2);    // out of range
    send_item(OP_RELEASE, 8'd255);  // out of range
    send_item(OP_RELEASE, 8'd0);    // push onto an empty list
    send_item(OP_RELEASE, 8'd1);    // behind the head
    send_item(OP_RELEASE, 8'd1);    // already free
    send_item(OP_ALLOC, 8'hFF);
    send_item(OP_ALLOC, 8'hFF);
    send_item(OP_ALLOC, 8'hFF);     // pool empty
    // zero count gives an empty pool, zero size gives zero offsets
    configure(32'd0, 32'd0);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_RELEASE, 8'd0);
    send_item(OP_RELEASE, 8'd128);
    // count above the pool size is clamped
    configure(32'd511, 32'd0);
    send_item(OP_ALLOC, 8'h00);
    send_item(OP_RELEASE, 8'd255);
  endtask

  // mostly allocate and release of held blocks, plus random noise requests
  task automatic random_phase(int unsigned n_items, int unsigned alloc_pct,
                              int unsigned noise_pct);
    int unsigned roll;
    bit          found;
    logic [7:0]  idx;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (roll < noise_pct + alloc_pct) begin
        send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
      end else begin
        sb.pick_held_block(found, idx);
        if (found) send_item(OP_RELEASE, idx);
        else send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_phases();
    configure(32'd8, 32'($urandom_range(1, 65535)));
    random_phase(160, 50, 10);
    configure(32'd1, 32'd65535);
    random_phase(80, 50, 15);
    // full pool with heavy allocation, runs dry near the end
    configure(32'd256, 32'd1);
    random_phase(330, 92, 3);
    configure(32'($urandom_range(2, 32)), 32'($urandom_range(1, 65535)));
    random_phase(200, 45, 15);
    configure(32'($urandom_range(257, 511)), 32'd0);
    random_phase(100, 60, 10);
    configure(32'd0, 32'($urandom_range(1, 65535)));
    random_phase(40, 50, 50);
    configure(32'($urandom_range(2, 16)), 32'($urandom_range(1, 65535)));
    random_phase(200, 50, 10);
    configure(32'd3, 32'd65535);
    random_phase(150, 50, 10);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_ALLOC;
    req_ch.block_index <= 8'd0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= 3'd0;
    pwdata             <= 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // the block rebuilds its list after reset; request handshakes wait it out
    directed_items();
    random_phases();

    // all stimulus taken: let the block answer, then watch for stray results
    quiesce();
    if (sb.expected_grants.size() != 0)
      sb.report($sformatf("%0d results never came", sb.expected_grants.size()));
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fbfa_pkg.sv
sv/fbfa_if.sv
sv/fbfa_cfg.sv
sv/fbfa_ctrl.sv
sv/fbfa_datapath.sv
sv/fixed_block_free_list_allocator_top.sv
sim/testbench.sv
